[src/qfs_pkg.sv]
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types and constants for the quoted field splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qfs_pkg;

  // Default number of field slots supported by the hardware
  localparam int QFS_MAX_FIELD_SLOTS = 256;
  // Default depth of the queue between front and back
  localparam int QFS_QUEUE_DEPTH     = 4;

  // Register reset values
  localparam logic [7:0] QFS_DELIM_RESET = 8'd44;
  localparam logic [8:0] QFS_MAXF_RESET  = 9'd256;

  // Register indexes
  localparam logic REG_DELIMITER  = 1'b0;
  localparam logic REG_MAX_FIELDS = 1'b1;

  // Special characters
  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_SEVEN  = 8'h37;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_STRING_END = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_t;

  // One result transaction
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] count;
  } result_t;

  // One queue entry: all results caused by one input byte
  typedef struct packed {
    logic    pair;   // two results: r0 then r1
    result_t r1;
    result_t r0;
  } entry_t;

endpackage

[src/qfs_front.sv]
// ----------------------------------------------------------------------------
// qfs_front
// Accepts source bytes, tracks quoting, escapes and field limits, and pushes
// the results of each byte as one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfs_front #(
  parameter int MAX_FIELD_SLOTS = qfs_pkg::QFS_MAX_FIELD_SLOTS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,     // [7:0] in_byte
  input  logic [7:0]      delimiter,
  input  logic [8:0]      max_fields,
  input  logic            q_full,
  output logic            push,
  output qfs_pkg::entry_t push_entry
);

  import qfs_pkg::*;

  localparam int         SLOT_CAP  = (MAX_FIELD_SLOTS > 256) ? 256 : MAX_FIELD_SLOTS;
  localparam logic [8:0] SLOT_CAP9 = 9'(SLOT_CAP);

  logic       in_quote, in_quote_next;
  logic       escape_pending, escape_pending_next;
  logic       octal_active, octal_active_next;
  logic [7:0] octal_value, octal_value_next;
  logic [7:0] field_index, field_index_next;
  logic       string_start, string_start_next;
  logic       discarding, discarding_next;

  logic       accept;
  logic [8:0] slots;
  logic [8:0] allowed;
  logic       is_octal;
  logic       flush_v;
  logic       main_v;
  result_t    flush_r;
  result_t    main_r;
  logic       blocked;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Field limit from the register, capped by the hardware slot count
  assign slots    = (max_fields > SLOT_CAP9) ? SLOT_CAP9 : max_fields;
  assign allowed  = (slots >= 9'd2) ? slots - 9'd2 : 9'd0;
  assign is_octal = (s_tdata >= CHR_ZERO) && (s_tdata <= CHR_SEVEN);

  // Decode one byte against the parser state
  always_comb begin
    in_quote_next       = in_quote;
    escape_pending_next = escape_pending;
    octal_active_next   = octal_active;
    octal_value_next    = octal_value;
    field_index_next    = field_index;
    string_start_next   = string_start;
    discarding_next     = discarding;
    flush_v             = 1'b0;
    main_v              = 1'b0;
    flush_r             = '{kind: KIND_DATA, data: octal_value, count: 8'd0};
    main_r              = '{kind: KIND_DATA, data: s_tdata, count: 8'd0};
    blocked             = 1'b0;

    if (discarding) begin
      // Drop bytes up to the terminator
      if (s_tdata == CHR_NUL) begin
        discarding_next     = 1'b0;
        in_quote_next       = 1'b0;
        escape_pending_next = 1'b0;
        octal_active_next   = 1'b0;
        octal_value_next    = 8'd0;
        field_index_next    = 8'd0;
        string_start_next   = 1'b1;
      end
    end else begin
      // Open a field: check the limit first
      if (string_start) begin
        if ({1'b0, field_index} >= allowed) begin
          main_v  = 1'b1;
          main_r  = '{kind: KIND_ERROR, data: 8'd0, count: 8'd0};
          blocked = 1'b1;
          if (s_tdata == CHR_NUL) begin
            in_quote_next       = 1'b0;
            escape_pending_next = 1'b0;
            octal_active_next   = 1'b0;
            octal_value_next    = 8'd0;
            field_index_next    = 8'd0;
            string_start_next   = 1'b1;
          end else begin
            discarding_next = 1'b1;
          end
        end else begin
          string_start_next = 1'b0;
          in_quote_next     = 1'b0;
        end
      end

      if (!blocked) begin
        if (escape_pending) begin
          // Byte after a backslash
          escape_pending_next = 1'b0;
          if (s_tdata == CHR_NUL) begin
            main_v              = 1'b1;
            main_r              = '{kind: KIND_STRING_END, data: 8'd0,
                                    count: field_index + 8'd1};
            in_quote_next       = 1'b0;
            octal_active_next   = 1'b0;
            octal_value_next    = 8'd0;
            field_index_next    = 8'd0;
            string_start_next   = 1'b1;
          end else if (is_octal) begin
            octal_active_next = 1'b1;
            octal_value_next  = {5'd0, s_tdata[2:0]};
          end else begin
            main_v = 1'b1;
          end
        end else if (octal_active && is_octal) begin
          // Accumulate another octal digit, wrapping at 8 bits
          octal_value_next = {octal_value[4:0], s_tdata[2:0]};
        end else begin
          // Flush a finished octal escape ahead of this byte
          if (octal_active) begin
            flush_v           = 1'b1;
            octal_active_next = 1'b0;
            octal_value_next  = 8'd0;
          end
          if (s_tdata == CHR_NUL) begin
            main_v              = 1'b1;
            main_r              = '{kind: KIND_STRING_END, data: 8'd0,
                                    count: field_index + 8'd1};
            in_quote_next       = 1'b0;
            escape_pending_next = 1'b0;
            octal_active_next   = 1'b0;
            octal_value_next    = 8'd0;
            field_index_next    = 8'd0;
            string_start_next   = 1'b1;
          end else if (s_tdata == delimiter) begin
            main_v = 1'b1;
            if (!in_quote_next) begin
              main_r            = '{kind: KIND_FIELD_END, data: 8'd0, count: 8'd0};
              string_start_next = 1'b1;
              in_quote_next     = 1'b0;
              if (field_index != 8'hFF) begin
                field_index_next = field_index + 8'd1;
              end
            end
          end else if (s_tdata == CHR_QUOTE) begin
            in_quote_next = !in_quote_next;
          end else if (s_tdata == CHR_BSLASH) begin
            escape_pending_next = 1'b1;
          end else begin
            main_v = 1'b1;
          end
        end
      end
    end
  end

  // Pack the results of this byte into one entry
  always_comb begin
    push            = accept && (flush_v || main_v);
    push_entry.pair = flush_v && main_v;
    push_entry.r0   = flush_v ? flush_r : main_r;
    push_entry.r1   = main_r;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote       <= 1'b0;
      escape_pending <= 1'b0;
      octal_active   <= 1'b0;
      octal_value    <= 8'd0;
      field_index    <= 8'd0;
      string_start   <= 1'b1;
      discarding     <= 1'b0;
    end else if (accept) begin
      in_quote       <= in_quote_next;
      escape_pending <= escape_pending_next;
      octal_active   <= octal_active_next;
      octal_value    <= octal_value_next;
      field_index    <= field_index_next;
      string_start   <= string_start_next;
      discarding     <= discarding_next;
    end
  end

endmodule

[src/qfs_fifo.sv]
// ----------------------------------------------------------------------------
// qfs_fifo
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfs_fifo #(
  parameter int DEPTH = qfs_pkg::QFS_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qfs_pkg::entry_t push_entry,
  input  logic            pop,
  output qfs_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  import qfs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/qfs_back.sv]
// ----------------------------------------------------------------------------
// qfs_back
// Drains queue entries and presents one result per transaction through an
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qfs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  qfs_pkg::entry_t q_head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // [7:0] out_byte, [15:8] field_count
  output logic [1:0]      m_tuser,   // [1:0] out_kind
  output logic            m_tlast    // out_last
);

  import qfs_pkg::*;

  logic    second;
  logic    load;
  logic    take;
  result_t sel;
  logic    sel_last;

  assign load     = !m_tvalid || m_tready;
  assign take     = load && !q_empty;
  assign sel      = second ? q_head.r1 : q_head.r0;
  assign sel_last = second || !q_head.pair;
  assign pop      = take && sel_last;

  // Step through the results of the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      second   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= !q_empty;
      if (take) begin
        second <= !sel_last;
      end
    end
  end

  // Hold the output payload
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {sel.count, sel.data};
      m_tuser <= sel.kind;
      m_tlast <= sel_last;
    end
  end

endmodule

[src/quoted_field_splitter.sv]
// ----------------------------------------------------------------------------
// quoted_field_splitter
// Splits a zero-terminated byte stream into fields with quoting and escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on s_tvalid/s_tready/s_tdata, one per transaction.
//   Results leave on m_tvalid/m_tready with m_tdata = {field_count, out_byte},
//   m_tuser = out_kind and m_tlast marking the final result of a source byte.
//   A byte gives zero, one or two results; bytes giving none leave no trace.
//   The APB port holds delimiter (address 0) and max_fields (address 4);
//   write them only while the block is idle.
// Timing:
//   The front decodes one byte per cycle while the queue is not full, into
//   a four-entry queue; the back sends one result per cycle while m_tready
//   is high, via the queue entry and the output register. Throughput is one
//   byte per cycle while each byte gives at most one result; a byte with two
//   results (a flushed octal escape, then another result) sends both in turn.
// Reset and stall:
//   Reset clears the parser and queue and restores delimiter 44 and
//   max_fields 256. When m_tready is low the output holds its transaction,
//   the queue fills, and s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_field_splitter #(
  parameter int MAX_FIELD_SLOTS = qfs_pkg::QFS_MAX_FIELD_SLOTS,
  parameter int QUEUE_DEPTH     = qfs_pkg::QFS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Source bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] field_count
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast,   // out_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import qfs_pkg::*;

  logic       [7:0] delimiter;
  logic       [8:0] max_fields;
  logic             cfg_write;
  logic             push;
  entry_t           push_entry;
  logic             pop;
  entry_t           q_head;
  logic             q_full;
  logic             q_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter  <= QFS_DELIM_RESET;
      max_fields <= QFS_MAXF_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DELIMITER:  delimiter  <= pwdata[7:0];
        REG_MAX_FIELDS: max_fields <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      REG_DELIMITER:  prdata = {24'd0, delimiter};
      REG_MAX_FIELDS: prdata = {23'd0, max_fields};
      default:        prdata = 32'd0;
    endcase
  end

  qfs_front #(
    .MAX_FIELD_SLOTS(MAX_FIELD_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .delimiter (delimiter),
    .max_fields(max_fields),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  qfs_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  qfs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

[test/quoted_field_splitter_tb.sv]
// ----------------------------------------------------------------------------
// quoted_field_splitter_tb
// Self-checking bench for the quoted field splitter.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the splitter state and registers.
// It predicts the result transactions for every source byte that the block
// accepts. Every result transaction that leaves the block is checked against
// the oldest prediction. The run goes through several delimiter and field
// limit settings. Each setting gets a burst of strings that are mostly well
// formed, with some raw noise between them. The bench varies source gaps and
// sink stalls, and now and then lets the block drain fully.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_field_splitter_tb;
  import qfs_pkg::*;

  localparam int  N_PHASES      = 8;
  localparam int  PHASE_ITEMS   = 65;
  localparam int  DRAIN_CYCLES  = 12;
  localparam int  CYCLE_LIMIT   = 400000;
  localparam byte unsigned CHR_A = 8'h61;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] count;
    logic       last;
  } split_result_t;

  // Tracks the parser state and holds the result transactions still due
  class split_scoreboard;
    logic [7:0]    delim;
    logic [8:0]    max_fields;
    logic          quoted, escaped, octal_on, opening, discarding;
    logic [7:0]    octal_acc, field_idx;
    split_result_t expected_results[$];
    split_result_t batch[$];
    int unsigned   failures;
    int unsigned   checked;

    function new();
      delim      = QFS_DELIM_RESET;
      max_fields = QFS_MAXF_RESET;
      discarding = 1'b0;
      failures   = 0;
      checked    = 0;
      start_string();
    endfunction

    function void start_string();
      quoted    = 1'b0;
      escaped   = 1'b0;
      octal_on  = 1'b0;
      octal_acc = 8'h00;
      field_idx = 8'h00;
      opening   = 1'b1;
    endfunction

    function void configure(logic idx, logic [8:0] value);
      if (idx == REG_DELIMITER) delim = value[7:0];
      else max_fields = value;
    endfunction

    function int fields_allowed();
      int slots;
      slots = max_fields;
      if (slots > QFS_MAX_FIELD_SLOTS) slots = QFS_MAX_FIELD_SLOTS;
      if (slots > 256) slots = 256;
      return (slots >= 2) ? slots - 2 : 0;
    endfunction

    function void add(kind_t kind, logic [7:0] data, logic [7:0] count);
      split_result_t r;
      r.kind  = kind;
      r.data  = data;
      r.count = count;
      r.last  = 1'b0;
      batch.push_back(r);
    endfunction

    // Advance the parser by one accepted source byte
    function void predict_byte(logic [7:0] b);
      split_result_t r;
      logic          consumed;
      logic          oct;
      batch.delete();
      consumed = 1'b0;
      oct = (b >= CHR_ZERO) && (b <= CHR_SEVEN);
      if (discarding) begin
        // drop everything up to the terminating zero
        if (b == CHR_NUL) begin
          discarding = 1'b0;
          start_string();
        end
      end else if (opening && (int'(field_idx) >= fields_allowed())) begin
        // field limit reached when opening: only an error result
        add(KIND_ERROR, 8'h00, 8'h00);
        if (b == CHR_NUL) start_string();
        else discarding = 1'b1;
      end else begin
        if (opening) begin
          opening = 1'b0;
          quoted  = 1'b0;
        end
        if (escaped) begin
          escaped = 1'b0;
          if (b == CHR_NUL) begin
            add(KIND_STRING_END, 8'h00, field_idx + 8'd1);
            start_string();
          end else if (oct) begin
            octal_on  = 1'b1;
            octal_acc = {5'd0, b[2:0]};
          end else begin
            add(KIND_DATA, b, 8'h00);
          end
        end else begin
          if (octal_on) begin
            if (oct) begin
              octal_acc = {octal_acc[4:0], b[2:0]};
              consumed  = 1'b1;
            end else begin
              add(KIND_DATA, octal_acc, 8'h00);
              octal_on  = 1'b0;
              octal_acc = 8'h00;
            end
          end
          if (!consumed) begin
            if (b == CHR_NUL) begin
              add(KIND_STRING_END, 8'h00, field_idx + 8'd1);
              start_string();
            end else if (b == delim) begin
              if (quoted) begin
                add(KIND_DATA, b, 8'h00);
              end else begin
                add(KIND_FIELD_END, 8'h00, 8'h00);
                if (field_idx < 8'd255) field_idx = field_idx + 8'd1;
                opening = 1'b1;
                quoted  = 1'b0;
              end
            end else if (b == CHR_QUOTE) begin
              quoted = !quoted;
            end else if (b == CHR_BSLASH) begin
              escaped = 1'b1;
            end else begin
              add(KIND_DATA, b, 8'h00);
            end
          end
        end
      end
      // flag the final result of this byte
      foreach (batch[i]) begin
        r = batch[i];
        r.last = (i == batch.size() - 1);
        expected_results.push_back(r);
      end
    endfunction

    // Compare one result transaction against the oldest prediction
    function void check_result(kind_t kind, logic [7:0] data, logic [7:0] count,
                               logic last);
      split_result_t e;
      checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_kind %0d out_byte %0h field_count %0d",
               kind, data, count);
        failures++;
        return;
      end
      e = expected_results.pop_front();
      if (e.kind !== kind) begin
        $error("out_kind: expected %0d, got %0d", e.kind, kind);
        failures++;
      end
      if (e.data !== data) begin
        $error("out_byte: expected %0h, got %0h", e.data, data);
        failures++;
      end
      if (e.count !== count) begin
        $error("field_count: expected %0d, got %0d", e.count, count);
        failures++;
      end
      if (e.last !== last) begin
        $error("out_last: expected %0b, got %0b", e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] out_byte, [15:8] field_count
  logic [1:0]  m_tuser;            // [1:0] out_kind
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  split_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent  = 0;
  int unsigned     tx_pct      = 0;
  int unsigned     rx_pct      = 0;
  logic [7:0]      cur_delim   = QFS_DELIM_RESET;
  logic [8:0]      cur_maxf    = QFS_MAXF_RESET;

  quoted_field_splitter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** quoted_field_splitter: FAILED **");
      $finish;
    end
  end

  // Stall the sink at the current rate
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_pct);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(kind_t'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tlast);
  end

  // Send one source byte, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_byte(b);
    items_sent++;
  endtask

  // Hold the source until every predicted result has left the block
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_register(input logic idx, input logic [8:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {23'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.configure(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (idx == REG_DELIMITER) ? {24'd0, value[7:0]} : {23'd0, value};
    if (readback !== want) begin
      $error("prdata at %0d: expected %0h, got %0h", {idx, 2'b00}, want, readback);
      sb.failures++;
    end
  endtask

  // Pick one content byte, biased toward the interesting characters
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 55) return CHR_QUOTE;
    if (r < 65) return CHR_BSLASH;
    if (r < 77) return 8'($urandom_range(CHR_ZERO, CHR_SEVEN));
    if (r < 87) return cur_delim;
    return 8'($urandom_range(1, 255));
  endfunction

  // Send a terminated string of nfields fields
  task automatic send_string(input int nfields, input int maxlen);
    for (int f = 0; f < nfields; f++) begin
      if (f != 0) send_byte(cur_delim);
      repeat ($urandom_range(0, maxlen)) send_byte(pick_char());
    end
    send_byte(CHR_NUL);
  endtask

  initial begin : stimulus
    logic [7:0]  delim_plan [N_PHASES];
    logic [8:0]  maxf_plan  [N_PHASES];
    int unsigned phase_end;
    int          allowed;
    logic        paused;
    sb = new();

    // Settings per phase, extremes first
    delim_plan = '{QFS_DELIM_RESET, 8'd1, 8'd255, CHR_QUOTE, CHR_BSLASH, CHR_ZERO,
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    maxf_plan  = '{QFS_MAXF_RESET, 9'd0, 9'd3, 9'd5, 9'd2, 9'd4, 9'd256,
                   9'($urandom_range(0, 256))};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      cur_delim = delim_plan[p];
      cur_maxf  = maxf_plan[p];
      write_register(REG_DELIMITER, {1'b0, cur_delim});
      write_register(REG_MAX_FIELDS, cur_maxf);
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 59; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 59; end
        default: begin tx_pct = 11; rx_pct = 11; end
      endcase

      if (p == 0) begin
        // quoted delimiter, escaped delimiter, octal escapes with flush and wrap
        send_byte(CHR_A);      send_byte(cur_delim);  send_byte(CHR_QUOTE);
        send_byte(8'h78);      send_byte(cur_delim);  send_byte(CHR_QUOTE);
        send_byte(CHR_BSLASH); send_byte(cur_delim);  send_byte(CHR_BSLASH);
        send_byte(8'h31);      send_byte(CHR_ZERO);   send_byte(8'h31);
        send_byte(cur_delim);  send_byte(CHR_BSLASH); send_byte(CHR_SEVEN);
        send_byte(CHR_SEVEN);  send_byte(CHR_SEVEN);  send_byte(8'h5A);
        send_byte(8'hFF);      send_byte(CHR_BSLASH); send_byte(CHR_QUOTE);
        // backslash right before the terminator, then an empty string
        send_byte(CHR_BSLASH); send_byte(CHR_NUL);    send_byte(CHR_NUL);
      end

      if (p == 6) begin
        // run a string well past the full field limit
        send_string(258, 0);
      end

      allowed   = sb.fields_allowed();
      phase_end = items_sent + PHASE_ITEMS;
      paused    = 1'b0;
      while (items_sent < phase_end) begin
        if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 12) begin
          // raw noise, terminators possibly included
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end else if (allowed <= 10 && $urandom_range(99) < 40) begin
          send_string($urandom_range(1, allowed + 3), 3);
        end else begin
          send_string($urandom_range(1, 5), 4);
        end
      end
      drain();
    end

    $display("%0d source bytes over %0d register settings, %0d results checked",
             items_sent, N_PHASES, sb.checked);
    $display("settings spanned delimiter 1..255 and max_fields 0..256");
    if (sb.failures == 0) begin
      $display("** quoted_field_splitter: PASSED **");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("** quoted_field_splitter: FAILED **");
    end
    $finish;
  end

endmodule
